// ----- design/qos_constraint_aggregator_assert.svh -----
// Assertion macros for the QoS constraint aggregator.
// Used by the top level; relies on signals named clk and rst_n in scope.
`ifndef QOS_CONSTRAINT_AGGREGATOR_ASSERT_SVH
`define QOS_CONSTRAINT_AGGREGATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define QCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define QCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define QCA_ASSERT_IMP(lbl, ante, cons, msg)
`define QCA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/qca_pkg.sv -----
// Shared types and constants of the QoS constraint aggregator.
// No dependencies.
package qca_pkg;

  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int SLOT_FW = 4;
  localparam int MASK_FW = 8;
  localparam int QCPU_FW = 3;
  localparam int CFG_IW  = 3;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  localparam logic [CFG_IW-1:0] REG_AGG_IS_MAX     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DEFAULT_VALUE  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_EMPTY_VALUE    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_PER_CPU_ENABLE = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PER_CPU_DEFAULT = 3'd4;

  localparam logic signed [DATA_W-1:0] RESET_TARGET = 32'sd2000000000;

  typedef logic signed [DATA_W-1:0] value_t;

endpackage

// ----- design/qca_if.sv -----
// Valid/ready channel interfaces for request transactions and results.
// Depends on qca_pkg.
interface qca_in_if import qca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [SLOT_FW-1:0] slot;
  value_t             request_value;
  logic               use_default;
  logic [MASK_FW-1:0] cpu_mask;
  logic [QCPU_FW-1:0] query_cpu;

  modport source (output valid, command, slot, request_value, use_default, cpu_mask,
                  query_cpu, input ready);
  modport sink (input valid, command, slot, request_value, use_default, cpu_mask,
                query_cpu, output ready);
endinterface

interface qca_out_if import qca_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t aggregate_value;
  logic   changed;
  value_t cpu_target;
  logic   status;

  modport source (output valid, aggregate_value, changed, cpu_target, status, input ready);
  modport sink (input valid, aggregate_value, changed, cpu_target, status, output ready);
endinterface

// ----- design/qos_constraint_aggregator.sv -----
// QoS constraint aggregator top level: request slot memory, scan and result register.
// Depends on qca_pkg, qca_if and qos_constraint_aggregator_assert.svh.
//
// Usage: each transaction on in_if adds, updates or removes one request slot,
// or only queries. Exactly one result per transaction leaves on out_if with the
// min or max aggregate, a changed flag, the target of the queried CPU and a
// status bit (1 when the command did not suit the slot state or its slot was out of range).
// Registers are to be written through cfg_we, cfg_index and cfg_wdata while
// idle; the block itself does not enforce this. A transaction is processed by
// one pass over the slot memory, one entry per cycle, which also writes the
// modified entry back in place. A new transaction is accepted only once the
// current one has finished and left its result in the result register.
// The input side is ready again while a result still waits: if the receiver
// stalls, the finish step of the following transaction waits for the result
// register. Reset clears all slots, sets the per-CPU targets to 2000000000
// and restores the register reset values; no clearing pass is needed.
`include "qos_constraint_aggregator_assert.svh"

module qos_constraint_aggregator import qca_pkg::*; #(
  parameter int REQUEST_SLOTS = 16,
  parameter int CPU_COUNT     = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  qca_in_if.sink            in_if,
  qca_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  localparam int SLOT_W  = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
  localparam int CPU_W   = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int ENTRY_W = DATA_W + CPU_COUNT;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic   agg_max_r;
  value_t default_r;
  value_t empty_r;
  logic   pce_r;
  value_t pc_default_r;

  logic [REQUEST_SLOTS-1:0] slot_valid_r;
  logic [ENTRY_W-1:0]       mem [REQUEST_SLOTS];
  logic [ENTRY_W-1:0]       rd_data_r;

  logic [CMD_W-1:0]     cmd_r;
  logic [SLOT_W-1:0]    tgt_r;
  value_t               val_r;
  logic [CPU_COUNT-1:0] mask_r;
  logic [QCPU_FW-1:0]   qcpu_r;
  logic                 status_r;
  logic                 act_r;

  logic [SLOT_W:0]   cnt_r;
  logic [SLOT_W-1:0] chk_idx_r;
  logic              chk_vld_r;

  logic   prev_any_r, curr_any_r;
  value_t prev_best_r, curr_best_r;
  logic [CPU_COUNT-1:0] cany_r;
  value_t               cbest_r   [CPU_COUNT];
  value_t               cpu_tgt_r [CPU_COUNT];
  value_t               cpu_new   [CPU_COUNT];

  logic   out_vld_r;
  value_t out_agg_r;
  logic   out_chg_r;
  value_t out_tgt_r;
  logic   out_status_r;

  logic in_acc;
  logic fin_go;
  logic [8:0] slot_ext;
  logic in_range;
  logic [SLOT_W-1:0] slot_idx;
  logic [63:0] mask_ext;
  logic [CPU_COUNT-1:0] mask_in;
  logic acc_status;

  logic [SLOT_W-1:0] rd_addr;
  logic rd_en;
  logic mem_we;
  logic old_v, new_v, hit;
  value_t old_val, new_val;
  logic [CPU_COUNT-1:0] old_cpus, upd_cpus;

  value_t prev_agg, curr_agg, q_tgt;
  logic [6:0] q_ext;
  logic [CPU_W-1:0] q_idx;

  assign in_acc  = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign fin_go  = (state_r == ST_FIN) && (!out_vld_r || out_if.ready);

  assign slot_ext = {5'b0, in_if.slot};
  assign in_range = (slot_ext < 9'(REQUEST_SLOTS));
  assign slot_idx = slot_ext[SLOT_W-1:0];
  assign mask_ext = {56'b0, in_if.cpu_mask};
  assign mask_in  = mask_ext[CPU_COUNT-1:0];

  always_comb begin
    acc_status = 1'b0;
    if (in_if.command != CMD_QUERY) begin
      if (!in_range) begin
        acc_status = 1'b1;
      end else if (in_if.command == CMD_ADD) begin
        acc_status = slot_valid_r[slot_idx];
      end else begin
        acc_status = !slot_valid_r[slot_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agg_max_r    <= 1'b0;
      default_r    <= RESET_TARGET;
      empty_r      <= RESET_TARGET;
      pce_r        <= 1'b1;
      pc_default_r <= RESET_TARGET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AGG_IS_MAX:      agg_max_r    <= cfg_wdata[0];
        REG_DEFAULT_VALUE:   default_r    <= $signed(cfg_wdata);
        REG_EMPTY_VALUE:     empty_r      <= $signed(cfg_wdata);
        REG_PER_CPU_ENABLE:  pce_r        <= cfg_wdata[0];
        REG_PER_CPU_DEFAULT: pc_default_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_r == (SLOT_W + 1)'(REQUEST_SLOTS)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rd_en   = (state_r == ST_SCAN) && (cnt_r < (SLOT_W + 1)'(REQUEST_SLOTS));
  assign rd_addr = cnt_r[SLOT_W-1:0];

  assign old_val  = $signed(rd_data_r[ENTRY_W-1:CPU_COUNT]);
  assign old_cpus = rd_data_r[CPU_COUNT-1:0];
  assign old_v    = slot_valid_r[chk_idx_r];
  assign hit      = act_r && (chk_idx_r == tgt_r);

  always_comb begin
    new_v    = old_v;
    new_val  = old_val;
    upd_cpus = old_cpus;
    if (hit) begin
      case (cmd_r)
        CMD_ADD: begin
          new_v    = 1'b1;
          new_val  = val_r;
          upd_cpus = (mask_r != '0) ? mask_r : {CPU_COUNT{1'b1}};
        end
        CMD_UPDATE: begin
          new_v   = 1'b1;
          new_val = val_r;
          if (mask_r != '0) upd_cpus = mask_r;
        end
        CMD_REMOVE: new_v = 1'b0;
        default: ;
      endcase
    end
  end

  assign mem_we = chk_vld_r && hit && (cmd_r == CMD_ADD || cmd_r == CMD_UPDATE);

  always_ff @(posedge clk) begin
    if (mem_we) mem[chk_idx_r] <= {new_val, upd_cpus};
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      act_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= rd_en;
      if (in_acc) begin
        cnt_r <= '0;
        act_r <= (in_if.command != CMD_QUERY) && !acc_status;
      end else if (rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) chk_idx_r <= rd_addr;
    if (in_acc) begin
      cmd_r    <= in_if.command;
      tgt_r    <= slot_idx;
      val_r    <= in_if.use_default ? default_r : in_if.request_value;
      mask_r   <= mask_in;
      qcpu_r   <= in_if.query_cpu;
      status_r <= acc_status;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_any_r <= 1'b0;
      curr_any_r <= 1'b0;
      cany_r     <= '0;
    end else if (chk_vld_r) begin
      if (old_v && (!prev_any_r ||
          (agg_max_r ? (old_val > prev_best_r) : (old_val < prev_best_r)))) begin
        prev_any_r  <= 1'b1;
        prev_best_r <= old_val;
      end
      if (new_v && (!curr_any_r ||
          (agg_max_r ? (new_val > curr_best_r) : (new_val < curr_best_r)))) begin
        curr_any_r  <= 1'b1;
        curr_best_r <= new_val;
      end
      for (int c = 0; c < CPU_COUNT; c++) begin
        if (new_v && upd_cpus[c] && (!cany_r[c] || new_val < cbest_r[c])) begin
          cany_r[c]  <= 1'b1;
          cbest_r[c] <= new_val;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CPU_COUNT; c++) begin
      if (pce_r) begin
        cpu_new[c] = cany_r[c] ? cbest_r[c] : pc_default_r;
      end else begin
        cpu_new[c] = cpu_tgt_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      for (int c = 0; c < CPU_COUNT; c++) cpu_tgt_r[c] <= RESET_TARGET;
    end else if (fin_go) begin
      if (act_r) slot_valid_r[tgt_r] <= (cmd_r != CMD_REMOVE);
      for (int c = 0; c < CPU_COUNT; c++) cpu_tgt_r[c] <= cpu_new[c];
    end
  end

  assign prev_agg = prev_any_r ? prev_best_r : empty_r;
  assign curr_agg = curr_any_r ? curr_best_r : empty_r;
  assign q_ext    = {4'b0, qcpu_r};
  assign q_idx    = q_ext[CPU_W-1:0];
  assign q_tgt    = (q_ext < 7'(CPU_COUNT)) ? cpu_new[q_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fin_go) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_agg_r    <= curr_agg;
      out_chg_r    <= (prev_agg != curr_agg);
      out_tgt_r    <= q_tgt;
      out_status_r <= status_r;
    end
  end

  assign out_if.valid           = out_vld_r;
  assign out_if.aggregate_value = out_agg_r;
  assign out_if.changed         = out_chg_r;
  assign out_if.cpu_target      = out_tgt_r;
  assign out_if.status          = out_status_r;

  `QCA_ASSERT_IMP(a_mem_we_scan, mem_we, state_r == ST_SCAN, "slot memory written outside the scan")
  `QCA_ASSERT_NXT(a_fin_result, fin_go, out_vld_r, "finished transaction left no result")
  `QCA_ASSERT_NXT(a_ignored_keeps, fin_go && !act_r, $stable(slot_valid_r), "slot table changed")

endmodule

// ----- dv/qca_target_checker.sv -----
// Checker for the QoS constraint aggregator: watches both channels and the register port.
// Predicts each result from its own copy of the slot table and compares field by field.
// Depends on qca_pkg and the channel interfaces in qca_if.
`timescale 1ns / 100ps

module qca_target_checker import qca_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int CPUS  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  qca_in_if                 in_ch,
  qca_out_if                out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                open_count
);

  typedef struct packed {
    value_t aggregate_value;
    logic   changed;
    value_t cpu_target;
    logic   status;
  } target_result_t;

  logic   agg_is_max;
  value_t default_val;
  value_t empty_val;
  logic   per_cpu_en;
  value_t per_cpu_dflt;

  logic            slot_live [SLOTS];
  value_t          slot_val  [SLOTS];
  logic [CPUS-1:0] slot_cpus [SLOTS];
  value_t          cpu_tgt   [CPUS];

  target_result_t expected_targets [$];
  target_result_t exp_r;
  int             mismatches;

  initial begin
    mismatches = 0;
  end

  function automatic value_t scan_aggregate();
    value_t best;
    logic   found;
    best  = empty_val;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && (!found || (agg_is_max ? (slot_val[i] > best)
                                                 : (slot_val[i] < best)))) begin
        best  = slot_val[i];
        found = 1'b1;
      end
    end
    return best;
  endfunction

  function automatic void rebuild_cpu_targets();
    value_t best;
    logic   found;
    for (int c = 0; c < CPUS; c++) begin
      best  = per_cpu_dflt;
      found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_live[i] && slot_cpus[i][c] && (!found || slot_val[i] < best)) begin
          best  = slot_val[i];
          found = 1'b1;
        end
      end
      cpu_tgt[c] = best;
    end
  endfunction

  function automatic target_result_t apply_request(input logic [CMD_W-1:0] cmd,
                                                   input logic [SLOT_FW-1:0] slot,
                                                   input value_t req_val,
                                                   input logic use_def,
                                                   input logic [MASK_FW-1:0] mask,
                                                   input logic [QCPU_FW-1:0] qcpu);
    target_result_t r;
    value_t         v;
    value_t         prior;
    v        = use_def ? default_val : req_val;
    prior    = scan_aggregate();
    r.status = 1'b0;
    case (cmd)
      CMD_ADD: begin
        if (slot_live[slot]) begin
          r.status = 1'b1;
        end else begin
          slot_live[slot] = 1'b1;
          slot_val[slot]  = v;
          slot_cpus[slot] = (mask[CPUS-1:0] != '0) ? mask[CPUS-1:0] : '1;
        end
      end
      CMD_UPDATE: begin
        if (!slot_live[slot]) begin
          r.status = 1'b1;
        end else begin
          slot_val[slot] = v;
          if (mask[CPUS-1:0] != '0) slot_cpus[slot] = mask[CPUS-1:0];
        end
      end
      CMD_REMOVE: begin
        if (!slot_live[slot]) r.status = 1'b1;
        else slot_live[slot] = 1'b0;
      end
      default: ;
    endcase
    r.aggregate_value = scan_aggregate();
    r.changed         = (r.aggregate_value != prior);
    if (per_cpu_en) rebuild_cpu_targets();
    r.cpu_target = cpu_tgt[qcpu];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      agg_is_max   = 1'b0;
      default_val  = RESET_TARGET;
      empty_val    = RESET_TARGET;
      per_cpu_en   = 1'b1;
      per_cpu_dflt = RESET_TARGET;
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_val[i]  = '0;
        slot_cpus[i] = '0;
      end
      for (int c = 0; c < CPUS; c++) cpu_tgt[c] = RESET_TARGET;
      expected_targets.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_AGG_IS_MAX:      agg_is_max   = cfg_wdata[0];
          REG_DEFAULT_VALUE:   default_val  = cfg_wdata;
          REG_EMPTY_VALUE:     empty_val    = cfg_wdata;
          REG_PER_CPU_ENABLE:  per_cpu_en   = cfg_wdata[0];
          REG_PER_CPU_DEFAULT: per_cpu_dflt = cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_targets.size() == 0) begin
          $display("%0t: result with no transaction pending: expected none, got %0d",
                   $time, out_ch.aggregate_value);
          mismatches++;
        end else begin
          exp_r = expected_targets.pop_front();
          if (out_ch.aggregate_value !== exp_r.aggregate_value) begin
            $display("%0t: aggregate_value expected %0d got %0d",
                     $time, exp_r.aggregate_value, out_ch.aggregate_value);
            mismatches++;
          end
          if (out_ch.changed !== exp_r.changed) begin
            $display("%0t: changed expected %0b got %0b", $time, exp_r.changed, out_ch.changed);
            mismatches++;
          end
          if (out_ch.cpu_target !== exp_r.cpu_target) begin
            $display("%0t: cpu_target expected %0d got %0d",
                     $time, exp_r.cpu_target, out_ch.cpu_target);
            mismatches++;
          end
          if (out_ch.status !== exp_r.status) begin
            $display("%0t: status expected %0b got %0b", $time, exp_r.status, out_ch.status);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_targets.push_back(apply_request(in_ch.command, in_ch.slot,
                                                 in_ch.request_value, in_ch.use_default,
                                                 in_ch.cpu_mask, in_ch.query_cpu));
      end
    end
    open_count <= expected_targets.size();
    fail_count <= mismatches;
  end

endmodule

// ----- dv/tb_qos_constraint_aggregator.sv -----
// Testbench top for the QoS constraint aggregator: clock, reset, stimulus and verdict.
// Drives directed and random request transactions with random idling and register phases.
// Depends on qca_pkg, qca_if, the block and qca_target_checker.
`timescale 1ns / 100ps

module tb_qos_constraint_aggregator;
  import qca_pkg::*;

  localparam int     SLOTS           = 16;
  localparam int     CPUS            = 8;
  localparam int     PHASES          = 5;
  localparam int     ITEMS_PER_PHASE = 105;
  localparam int     STALL_LIMIT     = 2000;
  localparam int     LONG_HOLD       = 250;
  localparam int     HOLD_AT         = 150;
  localparam int     SETTLE_CYCLES   = 30;
  localparam value_t VAL_MIN         = 32'sh8000_0000;
  localparam value_t VAL_MAX         = 32'sh7FFF_FFFF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;
  int                fails;
  int                awaiting;
  int                sent = 0;
  int                received = 0;
  int                quiet_cycles = 0;
  logic [SLOTS-1:0]  occupied = '0;

  qca_in_if  in_ch ();
  qca_out_if out_ch ();

  qos_constraint_aggregator #(
    .REQUEST_SLOTS(SLOTS),
    .CPU_COUNT    (CPUS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  qca_target_checker #(
    .SLOTS(SLOTS),
    .CPUS (CPUS)
  ) u_target_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fails),
    .open_count(awaiting)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [SLOT_FW-1:0] slot,
                               input value_t value, input logic use_def,
                               input logic [MASK_FW-1:0] mask, input logic [QCPU_FW-1:0] qcpu);
    int gap;
    gap = (sent >= 260 && sent < 330) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.slot          <= slot;
    in_ch.request_value <= value;
    in_ch.use_default   <= use_def;
    in_ch.cpu_mask      <= mask;
    in_ch.query_cpu     <= qcpu;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    case (cmd)
      CMD_ADD:    occupied[slot] = 1'b1;
      CMD_REMOVE: occupied[slot] = 1'b0;
      default: ;
    endcase
  endtask

  task automatic offer_random_request();
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_FW-1:0] slot;
    value_t             v;
    logic [MASK_FW-1:0] m;
    int                 pick;
    pick = $urandom_range(0, 99);
    cmd  = (pick < 30) ? CMD_ADD : (pick < 55) ? CMD_UPDATE : (pick < 85) ? CMD_REMOVE
                                                                          : CMD_QUERY;
    slot = SLOT_FW'($urandom_range(0, SLOTS - 1));
    if (cmd != CMD_QUERY && $urandom_range(0, 99) < 85) begin
      for (int k = 0; k < SLOTS && ((cmd == CMD_ADD) == occupied[slot]); k++) begin
        slot = slot + 1'b1;
      end
    end
    case ($urandom_range(0, 7))
      0:       v = VAL_MIN;
      1:       v = VAL_MAX;
      2, 3, 4: v = value_t'(int'($urandom_range(0, 40)) - 20);
      default: v = $urandom();
    endcase
    case ($urandom_range(0, 3))
      0:       m = '0;
      1:       m = MASK_FW'(1) << $urandom_range(0, CPUS - 1);
      default: m = MASK_FW'($urandom());
    endcase
    offer_request(cmd, slot, v, $urandom_range(0, 99) < 15, m,
                  QCPU_FW'($urandom_range(0, CPUS - 1)));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_registers(input logic is_max, input value_t dflt, input value_t empty,
                                input logic pc_en, input value_t pc_dflt);
    logic [CFG_IW-1:0] regs [5];
    logic [DATA_W-1:0] data [5];
    regs = '{REG_AGG_IS_MAX, REG_DEFAULT_VALUE, REG_EMPTY_VALUE, REG_PER_CPU_ENABLE,
             REG_PER_CPU_DEFAULT};
    data = '{{{(DATA_W - 1){1'b0}}, is_max}, dflt, empty, {{(DATA_W - 1){1'b0}}, pc_en},
             pc_dflt};
    for (int k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_wdata <= data[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : result_sink
    int pause;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (received == HOLD_AT) pause = LONG_HOLD;
      else if (received >= 320 && received < 400) pause = 0;
      else pause = $urandom_range(0, 7);
      if (pause > 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      received++;
    end
  end

  initial begin
    cfg_we              <= 1'b0;
    cfg_index           <= REG_AGG_IS_MAX;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_QUERY;
    in_ch.slot          <= '0;
    in_ch.request_value <= '0;
    in_ch.use_default   <= 1'b0;
    in_ch.cpu_mask      <= '0;
    in_ch.query_cpu     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: minimum aggregation with per-CPU targets.
    offer_request(CMD_QUERY,  4'd0,  32'sd0,  1'b0, 8'h00, 3'd0);
    offer_request(CMD_REMOVE, 4'd3,  32'sd0,  1'b0, 8'h00, 3'd1);
    offer_request(CMD_UPDATE, 4'd5,  32'sd9,  1'b0, 8'h10, 3'd2);
    offer_request(CMD_ADD,    4'd0,  VAL_MAX, 1'b0, 8'h00, 3'd7);
    offer_request(CMD_ADD,    4'd0,  -32'sd3, 1'b0, 8'h04, 3'd2);
    offer_request(CMD_ADD,    4'd15, VAL_MIN, 1'b0, 8'h80, 3'd7);
    offer_request(CMD_ADD,    4'd7,  32'sd123, 1'b1, 8'h01, 3'd0);
    offer_request(CMD_UPDATE, 4'd15, 32'sd0,  1'b0, 8'h00, 3'd7);
    offer_request(CMD_UPDATE, 4'd7,  -32'sd1, 1'b0, 8'h0F, 3'd3);
    offer_request(CMD_UPDATE, 4'd15, 32'sd5,  1'b0, 8'h02, 3'd7);
    offer_request(CMD_QUERY,  4'd9,  32'sd0,  1'b0, 8'hFF, 3'd1);
    offer_request(CMD_REMOVE, 4'd0,  32'sd0,  1'b0, 8'h00, 3'd7);
    drain_results();

    // Maximum aggregation with per-CPU targets frozen.
    load_registers(1'b1, VAL_MIN, VAL_MIN, 1'b0, -32'sd5);
    offer_request(CMD_QUERY,  4'd0,  32'sd0,  1'b0, 8'h00, 3'd1);
    offer_request(CMD_ADD,    4'd1,  32'sd77, 1'b1, 8'hFF, 3'd0);
    offer_request(CMD_ADD,    4'd2,  VAL_MAX, 1'b0, 8'h00, 3'd5);
    offer_request(CMD_REMOVE, 4'd2,  32'sd0,  1'b0, 8'h00, 3'd5);
    offer_request(CMD_REMOVE, 4'd1,  32'sd0,  1'b0, 8'h00, 3'd6);
    offer_request(CMD_REMOVE, 4'd7,  32'sd0,  1'b0, 8'h00, 3'd3);
    offer_request(CMD_REMOVE, 4'd15, 32'sd0,  1'b0, 8'h00, 3'd1);
    drain_results();

    load_registers(1'b0, VAL_MAX, VAL_MAX, 1'b1, VAL_MIN);
    offer_request(CMD_QUERY,  4'd0,  32'sd0,  1'b0, 8'h00, 3'd4);
    offer_request(CMD_ADD,    4'd9,  32'sd0,  1'b1, 8'h00, 3'd4);
    offer_request(CMD_UPDATE, 4'd9,  VAL_MIN, 1'b0, 8'h55, 3'd1);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: load_registers(1'b1, VAL_MIN, VAL_MAX, 1'b1, VAL_MIN);
        1: load_registers(1'b0, VAL_MAX, VAL_MIN, 1'b0, 32'sd0);
        4: load_registers(1'b0, RESET_TARGET, RESET_TARGET, 1'b1, RESET_TARGET);
        default: load_registers(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                                $urandom_range(0, 3) != 0, $urandom());
      endcase
      repeat (ITEMS_PER_PHASE) offer_random_request();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && awaiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
